FILE: hdl/eit_pkg.sv
// Shared types and constants for the event interest table.
`timescale 1ns / 1ps
`default_nettype none
package eit_pkg;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_DEL    = 3'd1,
    CMD_MOD    = 3'd2,
    CMD_WAIT   = 3'd3,
    CMD_SETRDY = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BADF  = 3'd1,
    ST_EXIST = 3'd2,
    ST_FULL  = 3'd3,
    ST_INVAL = 3'd4,
    ST_NOENT = 3'd5
  } stat_e;

  localparam logic [4:0] EV_DEFINED = 5'h1D;
  localparam logic [6:0] WAIT_CAP   = 7'd64;
  localparam int         SLOT_W     = 106;

  typedef struct packed {
    logic       ready;
    logic       clr_wr;
    logic       scan_rst;
    logic       scan_inc;
    logic       slot_rd;
    logic       fd_rd;
    logic       note_free;
    logic       push_pend;
    logic       emit_last;
    logic       emit_stat;
    stat_e      stat_code;
    logic       slot_wr;
    logic       slot_wr_free;
    logic       set_active;
    logic       clr_active;
    logic       rdy_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic       req_fire;
    logic       clr_done;
    logic [2:0] cmd;
    logic       fd_bad;
    logic       fd_open;
    logic       max_zero;
    logic       scan_end;
    logic       fd_match;
    logic       slot_act;
    logic       ev_hit;
    logic       have_free;
    logic       have_pend;
    logic       cnt_full;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: hdl/eit_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface eit_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [9:0]  fd;
  logic        fd_open;
  logic [31:0] events;
  logic [63:0] user_data;
  logic [6:0]  max_events;
  logic [4:0]  ready_mask;
  modport source (output valid, cmd, fd, fd_open, events, user_data, max_events, ready_mask,
                  input ready);
  modport sink (input valid, cmd, fd, fd_open, events, user_data, max_events, ready_mask,
                output ready);
endinterface

interface eit_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        event_valid;
  logic [4:0]  ready_events;
  logic [63:0] out_data;
  logic [6:0]  ready_count;
  logic        last;
  modport source (output valid, status, event_valid, ready_events, out_data, ready_count, last,
                  input ready);
  modport sink (input valid, status, event_valid, ready_events, out_data, ready_count, last,
                output ready);
endinterface
`default_nettype wire

FILE: hdl/eit_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module eit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: hdl/eit_dp.sv
// Datapath: request registers, slot table, readiness memory, pending event and result register.
`timescale 1ns / 1ps
`default_nettype none
module eit_dp #(
  parameter int TABLE_SLOTS = 64,
  parameter int FD_COUNT    = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  eit_req_if.sink               req,
  eit_res_if.source             res,
  input  wire eit_pkg::dp_cmd_t cmd,
  output eit_pkg::dp_stat_t     stat
);
  localparam int SA = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int FA = $clog2(FD_COUNT);

  logic [2:0]  req_cmd;
  logic [9:0]  req_fd;
  logic        req_open;
  logic [31:0] req_events;
  logic [63:0] req_data;
  logic [6:0]  req_max;
  logic [4:0]  req_mask;

  logic [TABLE_SLOTS-1:0] active;
  logic [SA-1:0] idx;
  logic [SA-1:0] free_idx;
  logic          have_free;
  logic [FA-1:0] clr_cnt;
  logic [6:0]    count;
  logic [6:0]    count_inc;

  logic          pend_valid;
  logic [4:0]    pend_rev;
  logic [63:0]   pend_data;
  logic [6:0]    pend_cnt;

  logic [eit_pkg::SLOT_W-1:0] slot_rdata;
  logic [eit_pkg::SLOT_W-1:0] slot_wdata;
  logic [SA-1:0]              slot_waddr;
  logic [9:0]                 s_fd;
  logic [31:0]                s_events;
  logic [63:0]                s_data;
  logic [4:0]                 rdy_rdata;
  logic [4:0]                 rdy_wdata;
  logic [FA-1:0]              rdy_waddr;
  logic                       rdy_we;
  logic [4:0]                 rev_cur;
  logic                       fire;
  logic                       out_free;
  logic                       emit;

  assign req.ready = cmd.ready;
  assign fire      = req.valid && cmd.ready;
  assign out_free  = !res.valid || res.ready;
  assign emit      = cmd.emit_stat || cmd.emit_last || (cmd.push_pend && pend_valid);

  assign s_fd      = slot_rdata[105:96];
  assign s_events  = slot_rdata[95:64];
  assign s_data    = slot_rdata[63:0];
  assign rev_cur   = rdy_rdata & s_events[4:0];
  assign count_inc = count + 7'd1;

  assign slot_wdata = {req_fd, req_events, req_data};
  assign slot_waddr = cmd.slot_wr_free ? free_idx : idx;
  assign rdy_we     = cmd.clr_wr || cmd.rdy_wr;
  assign rdy_waddr  = cmd.clr_wr ? clr_cnt : FA'(req_fd);
  assign rdy_wdata  = cmd.clr_wr ? 5'd0 : (req_mask & eit_pkg::EV_DEFINED);

  eit_ram #(.WIDTH(eit_pkg::SLOT_W), .DEPTH(TABLE_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (cmd.slot_wr),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (cmd.slot_rd),
    .raddr (idx),
    .rdata (slot_rdata)
  );

  eit_ram #(.WIDTH(5), .DEPTH(FD_COUNT)) u_rdy_ram (
    .clk   (clk),
    .we    (rdy_we),
    .waddr (rdy_waddr),
    .wdata (rdy_wdata),
    .re    (cmd.fd_rd),
    .raddr (FA'(s_fd)),
    .rdata (rdy_rdata)
  );

  always_comb begin
    stat.req_fire  = fire;
    stat.clr_done  = (clr_cnt == FA'(FD_COUNT - 1));
    stat.cmd       = req_cmd;
    stat.fd_bad    = (32'(req_fd) >= 32'(FD_COUNT));
    stat.fd_open   = req_open;
    stat.max_zero  = (req_max == 7'd0);
    stat.scan_end  = (idx == SA'(TABLE_SLOTS - 1));
    stat.slot_act  = active[idx];
    stat.fd_match  = active[idx] && (s_fd == req_fd);
    stat.ev_hit    = (rev_cur != 5'd0);
    stat.have_free = have_free;
    stat.have_pend = pend_valid;
    stat.cnt_full  = (count_inc == req_max);
    stat.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      req_cmd    <= req.cmd;
      req_fd     <= req.fd;
      req_open   <= req.fd_open;
      req_events <= req.events;
      req_data   <= req.user_data;
      req_max    <= (req.max_events > eit_pkg::WAIT_CAP) ? eit_pkg::WAIT_CAP : req.max_events;
      req_mask   <= req.ready_mask;
    end
    if (cmd.scan_rst) begin
      idx <= '0;
    end else if (cmd.scan_inc) begin
      idx <= idx + SA'(1);
    end
    if (cmd.note_free) begin
      free_idx <= idx;
    end
    if (cmd.push_pend) begin
      pend_rev  <= rev_cur;
      pend_data <= s_data;
      pend_cnt  <= count_inc;
    end
    if (emit) begin
      if (cmd.emit_stat) begin
        res.status       <= cmd.stat_code;
        res.event_valid  <= 1'b0;
        res.ready_events <= 5'd0;
        res.out_data     <= 64'd0;
        res.ready_count  <= 7'd0;
        res.last         <= 1'b1;
      end else begin
        res.status       <= eit_pkg::ST_OK;
        res.event_valid  <= 1'b1;
        res.ready_events <= pend_rev;
        res.out_data     <= pend_data;
        res.ready_count  <= pend_cnt;
        res.last         <= cmd.emit_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      have_free  <= 1'b0;
      clr_cnt    <= '0;
      count      <= 7'd0;
      pend_valid <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + FA'(1);
      end
      if (cmd.set_active) begin
        active[free_idx] <= 1'b1;
      end
      if (cmd.clr_active) begin
        active[idx] <= 1'b0;
      end
      if (fire) begin
        have_free  <= 1'b0;
        count      <= 7'd0;
        pend_valid <= 1'b0;
      end else begin
        if (cmd.note_free) begin
          have_free <= 1'b1;
        end
        if (cmd.push_pend) begin
          count      <= count_inc;
          pend_valid <= 1'b1;
        end else if (cmd.emit_last) begin
          pend_valid <= 1'b0;
        end
      end
      if (emit) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  a_pend_cnt: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (pend_cnt != 7'd0) && (pend_cnt <= eit_pkg::WAIT_CAP))
    else $error("pending event count out of range");
  a_ev_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.event_valid) |-> (res.ready_events != 5'd0))
    else $error("event result with empty ready mask");
  a_plain_res: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.event_valid) |-> (res.last && res.ready_count == 7'd0))
    else $error("plain result not final or with count");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result register overwritten");
endmodule
`default_nettype wire

FILE: hdl/eit_ctrl.sv
// Controller state machine sequencing slot scans and result emission.
`timescale 1ns / 1ps
`default_nettype none
module eit_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire eit_pkg::dp_stat_t stat,
  output eit_pkg::dp_cmd_t       cmd
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD_SLOT, S_RD_FD, S_EVAL, S_ADD_FIN, S_WAIT_FIN, S_RESP
  } state_t;

  state_t         state, state_next;
  eit_pkg::stat_e resp_st, resp_st_next;

  always_comb begin
    state_next   = state;
    resp_st_next = resp_st;
    cmd          = '0;
    cmd.stat_code = resp_st;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (stat.req_fire) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.scan_rst = 1'b1;
        state_next   = S_RD_SLOT;
        if (stat.cmd == eit_pkg::CMD_WAIT) begin
          if (stat.max_zero) begin
            resp_st_next = eit_pkg::ST_INVAL;
            state_next   = S_RESP;
          end
        end else if (stat.cmd == eit_pkg::CMD_SETRDY) begin
          state_next = S_RESP;
          if (stat.fd_bad) begin
            resp_st_next = eit_pkg::ST_BADF;
          end else begin
            cmd.rdy_wr   = 1'b1;
            resp_st_next = eit_pkg::ST_OK;
          end
        end else if (!stat.fd_open || stat.fd_bad) begin
          resp_st_next = eit_pkg::ST_BADF;
          state_next   = S_RESP;
        end
      end
      S_RD_SLOT: begin
        cmd.slot_rd = 1'b1;
        state_next  = S_RD_FD;
      end
      S_RD_FD: begin
        cmd.fd_rd  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        case (stat.cmd)
          eit_pkg::CMD_WAIT: begin
            if (stat.slot_act && stat.ev_hit) begin
              if (!stat.have_pend || stat.out_free) begin
                cmd.push_pend = 1'b1;
                if (stat.cnt_full || stat.scan_end) begin
                  state_next = S_WAIT_FIN;
                end else begin
                  cmd.scan_inc = 1'b1;
                  state_next   = S_RD_SLOT;
                end
              end
            end else if (stat.scan_end) begin
              state_next = S_WAIT_FIN;
            end else begin
              cmd.scan_inc = 1'b1;
              state_next   = S_RD_SLOT;
            end
          end
          eit_pkg::CMD_ADD: begin
            if (stat.fd_match) begin
              resp_st_next = eit_pkg::ST_EXIST;
              state_next   = S_RESP;
            end else begin
              cmd.note_free = !stat.slot_act && !stat.have_free;
              if (stat.scan_end) begin
                state_next = S_ADD_FIN;
              end else begin
                cmd.scan_inc = 1'b1;
                state_next   = S_RD_SLOT;
              end
            end
          end
          default: begin
            if (stat.fd_match) begin
              state_next = S_RESP;
              if (stat.cmd == eit_pkg::CMD_DEL) begin
                cmd.clr_active = 1'b1;
                resp_st_next   = eit_pkg::ST_OK;
              end else if (stat.cmd == eit_pkg::CMD_MOD) begin
                cmd.slot_wr  = 1'b1;
                resp_st_next = eit_pkg::ST_OK;
              end else begin
                resp_st_next = eit_pkg::ST_INVAL;
              end
            end else if (stat.scan_end) begin
              resp_st_next = eit_pkg::ST_NOENT;
              state_next   = S_RESP;
            end else begin
              cmd.scan_inc = 1'b1;
              state_next   = S_RD_SLOT;
            end
          end
        endcase
      end
      S_ADD_FIN: begin
        state_next = S_RESP;
        if (stat.have_free) begin
          cmd.slot_wr      = 1'b1;
          cmd.slot_wr_free = 1'b1;
          cmd.set_active   = 1'b1;
          resp_st_next     = eit_pkg::ST_OK;
        end else begin
          resp_st_next = eit_pkg::ST_FULL;
        end
      end
      S_WAIT_FIN: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
          if (stat.have_pend) begin
            cmd.emit_last = 1'b1;
          end else begin
            cmd.emit_stat = 1'b1;
            cmd.stat_code = eit_pkg::ST_OK;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.emit_stat = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      resp_st <= eit_pkg::ST_OK;
    end else begin
      state   <= state_next;
      resp_st <= resp_st_next;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> (state == S_IDLE))
    else $error("request taken outside idle");
  a_fire_decode: assert property (@(posedge clk) disable iff (rst)
    stat.req_fire |=> (state == S_DECODE))
    else $error("accepted request not decoded");
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_stat && (cmd.emit_last || cmd.push_pend)))
    else $error("two result sources at once");
endmodule
`default_nettype wire

FILE: hdl/event_interest_table.sv
// Top level of the event interest table.
// Flow from accept to result: set readiness and requests rejected at decode go straight to the
// response; add, delete, modify and unknown ops scan up to every slot, each slot through the
// RD_SLOT, RD_FD and EVAL states; wait scans the same way and also stalls on the output. One
// request at a time, taken only in idle after the result of the previous one has been issued;
// the slot scan sets the rate. Reset clears all slots, then a clearing pass zeroes every entry
// of the readiness memory while no request is taken.
`timescale 1ns / 1ps
`default_nettype none
module event_interest_table #(
  parameter int TABLE_SLOTS = 64,
  parameter int FD_COUNT    = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  eit_req_if.sink   req,
  eit_res_if.source res
);
  eit_pkg::dp_cmd_t  cmd;
  eit_pkg::dp_stat_t stat;

  eit_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  eit_dp #(.TABLE_SLOTS(TABLE_SLOTS), .FD_COUNT(FD_COUNT)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .res  (res),
    .cmd  (cmd),
    .stat (stat)
  );
endmodule
`default_nettype wire
